FILE: design/sfi_pkg.sv
// Shared types and constants for the servo frame interpolator.
package sfi_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W        = 4;
  localparam int POS_W       = 16;
  localparam int DUR_W       = 16;
  localparam int TIME_W      = 32;
  localparam int FRAC_W      = 15;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_DISABLE = 2'd3
  } func_t;

  // write request into the channel pose memory
  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] addr;
    logic [POS_W-1:0]    tgt;
    logic [POS_W-1:0]    strt;
  } mem_wr_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/sfi_chan_mem.sv
// Channel pose memory: target and start position per channel, registered read.
module sfi_chan_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfi_pkg::mem_wr_t              wr,
  input  logic                          rd_en,
  input  logic [sfi_pkg::CH_IDX_W-1:0]  rd_addr,
  output logic [2*sfi_pkg::POS_W-1:0]   rd_data   // {target, start}
);
  import sfi_pkg::*;

  logic [2*POS_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [2*POS_W-1:0] raw_r;
  logic               raw_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.tgt, wr.strt};
    end
    if (rd_en) begin
      raw_r <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      raw_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        raw_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = raw_vld_r ? raw_r : '0;

endmodule

FILE: design/sfi_div.sv
// Restoring divider for the Q15 frame fraction: 32767*elapsed/duration.
module sfi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sfi_pkg::DUR_W-1:0]   elapsed,
  input  logic [sfi_pkg::DUR_W-1:0]   duration,
  output sfi_pkg::div_stat_t          stat,
  output logic [sfi_pkg::FRAC_W-1:0]  quot
);
  import sfi_pkg::*;

  localparam int NUM_W = DUR_W + FRAC_W;
  localparam int CNT_W = $clog2(FRAC_W);

  logic [NUM_W-1:0]  num;
  logic [DUR_W-1:0]  rem_r;
  logic [FRAC_W-1:0] sh_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DUR_W:0]    trial;
  logic              ge;

  // 32767*e = (e << 15) - e; elapsed < duration keeps the quotient below 2^15
  assign num   = {elapsed, FRAC_W'(0)} - NUM_W'(elapsed);
  assign trial = {rem_r, sh_r[FRAC_W-1]};
  assign ge    = trial >= {1'b0, duration};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:FRAC_W];
      sh_r  <= num[FRAC_W-1:0];
      cnt_r <= CNT_W'(FRAC_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? DUR_W'(trial - {1'b0, duration}) : trial[DUR_W-1:0];
      sh_r  <= {sh_r[FRAC_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = sh_r;

endmodule

FILE: design/servo_frame_interpolator_unit.sv
// Servo frame interpolator top level: command decode, tick sequencer, output stage.
//
// Input channel (in_*): one transfer per command. in_tuser carries the function
// (load channel, start frame, tick, disable); in_tdata the channel, poses,
// active flag, duration and current time. Load, start and disable produce no
// result and keep the unit idle. A tick produces one result per active channel in
// ascending channel order on the out_* channel, with frame_done on out_tuser
// and out_tlast on the last result of the tick.
// Tick steps: accept, then the Q15 fraction divider (one quotient bit a cycle)
// unless the frame has finished, then a read step per channel passed, which
// reads the memory only for an active channel, and a multiply and an output
// step per active channel, since poses live in a memory with one read port,
// read one channel at a time.
// in_tready is high only while no tick is in progress; an output register
// parts the two sides, so a new command is taken while the last result waits.
// When the receiver stalls the sequencer holds at the output step.
// Reset (rst_n low, synchronous): all poses read as zero, no channel active,
// done set, start time and duration zero.
module servo_frame_interpolator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // channel[3:0], target_position[19:4], start_position[35:20],
  // channel_active[36], duration_ms[52:37], now_ms[84:53], zero fill
  input  logic [sfi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[1:0]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_channel[3:0], out_position[19:4], zero fill
  output logic [sfi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // frame_done[0]
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import sfi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DSTART,
    S_DIV,
    S_RD,
    S_MUL,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CH_IDX_W-1:0] ch_r, ch_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;
  logic [TIME_W-1:0]   start_time_r, start_time_nxt;
  logic [DUR_W-1:0]    dur_r, dur_nxt;
  logic                done_r, done_nxt;
  logic                fin_r, fin_nxt;
  logic [DUR_W-1:0]    elapsed_r, elapsed_nxt;
  logic signed [32:0]  prod_r, prod_nxt;
  logic [POS_W-1:0]    tgt_r, tgt_nxt;
  logic [POS_W-1:0]    prev_r, prev_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [CH_W-1:0]     out_ch_r, out_ch_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic                out_done_r, out_done_nxt;
  logic                out_last_r, out_last_nxt;

  // input fields
  func_t            in_func;
  logic [CH_W-1:0]  in_channel;
  logic [POS_W-1:0] in_target;
  logic [POS_W-1:0] in_start;
  logic             in_active;
  logic [DUR_W-1:0] in_duration;
  logic [TIME_W-1:0] in_now;

  logic              in_acc;
  logic              ch_ok;
  logic [TIME_W-1:0] elapsed;
  logic              fin_now;
  logic              more_above;
  logic              slot_free;

  mem_wr_t            mem_wr;
  logic               mem_rd_en;
  logic [2*POS_W-1:0] mem_rd_data;
  div_stat_t          div_stat;
  logic [FRAC_W-1:0]  frac;

  // lerp datapath
  logic [POS_W-1:0]   cur_prev, cur_next;
  logic [POS_W:0]     ph17, nh17;
  logic signed [POS_W:0] diff_s;
  logic signed [POS_W-1:0] frac_s;
  logic [17:0]        step;
  logic signed [18:0] sum;
  logic [POS_W-1:0]   lerp_pos;

  assign in_func     = func_t'(in_tuser);
  assign in_channel  = in_tdata[3:0];
  assign in_target   = in_tdata[19:4];
  assign in_start    = in_tdata[35:20];
  assign in_active   = in_tdata[36];
  assign in_duration = in_tdata[52:37];
  assign in_now      = in_tdata[84:53];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ch_ok     = {28'd0, in_channel} < 32'(CHANNELS);

  assign elapsed = in_now - start_time_r;
  assign fin_now = (elapsed[TIME_W-1:DUR_W] != '0) || (elapsed[DUR_W-1:0] >= dur_r);

  assign slot_free = !out_vld_r || out_tready;

  always_comb begin
    more_above = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      if (active_r[j] && (j > int'(ch_r))) begin
        more_above = 1'b1;
      end
    end
  end

  assign mem_wr.en   = in_acc && (in_func == FUNC_LOAD) && ch_ok;
  assign mem_wr.addr = CH_IDX_W'(in_channel);
  assign mem_wr.tgt  = in_target;
  assign mem_wr.strt = in_start;
  assign mem_rd_en   = (state_r == S_RD) && active_r[ch_r];

  sfi_chan_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (ch_r),
    .rd_data (mem_rd_data)
  );

  sfi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DSTART),
    .elapsed  (elapsed_r),
    .duration (dur_r),
    .stat     (div_stat),
    .quot     (frac)
  );

  // halvings truncate toward zero
  assign cur_prev = mem_rd_data[POS_W-1:0];
  assign cur_next = mem_rd_data[2*POS_W-1:POS_W];
  assign ph17     = {cur_prev[POS_W-1], cur_prev} + {{POS_W{1'b0}}, cur_prev[POS_W-1]};
  assign nh17     = {cur_next[POS_W-1], cur_next} + {{POS_W{1'b0}}, cur_next[POS_W-1]};
  assign diff_s   = $signed({nh17[POS_W], nh17[POS_W:1]}) -
                    $signed({ph17[POS_W], ph17[POS_W:1]});
  assign frac_s   = $signed({1'b0, frac});

  // floor(prod / 2^15), doubled and added to the start pose, then saturated
  assign step = prod_r[32:15];
  assign sum  = $signed({{3{prev_r[POS_W-1]}}, prev_r}) + $signed({step, 1'b0});
  always_comb begin
    if (sum > 19'sd32767) begin
      lerp_pos = 16'h7FFF;
    end else if (sum < -19'sd32768) begin
      lerp_pos = 16'h8000;
    end else begin
      lerp_pos = sum[POS_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    active_nxt     = active_r;
    start_time_nxt = start_time_r;
    dur_nxt        = dur_r;
    done_nxt       = done_r;
    fin_nxt        = fin_r;
    elapsed_nxt    = elapsed_r;
    prod_nxt       = prod_r;
    tgt_nxt        = tgt_r;
    prev_nxt       = prev_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_ch_nxt     = out_ch_r;
    out_pos_nxt    = out_pos_r;
    out_done_nxt   = out_done_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_LOAD: begin
              if (ch_ok) begin
                active_nxt[CH_IDX_W'(in_channel)] = in_active;
              end
            end
            FUNC_START: begin
              start_time_nxt = in_now;
              dur_nxt        = in_duration;
              done_nxt       = 1'b0;
            end
            FUNC_DISABLE: begin
              active_nxt = '0;
              done_nxt   = 1'b1;
            end
            FUNC_TICK: begin
              fin_nxt     = fin_now;
              elapsed_nxt = elapsed[DUR_W-1:0];
              ch_nxt      = '0;
              if (fin_now) begin
                done_nxt = 1'b1;
              end
              if (active_r != '0) begin
                state_nxt = fin_now ? S_RD : S_DSTART;
              end
            end
            default: ;
          endcase
        end
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (active_r[ch_r]) begin
          state_nxt = S_MUL;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      S_MUL: begin
        prod_nxt  = 33'(diff_s) * 33'(frac_s);
        tgt_nxt   = cur_next;
        prev_nxt  = cur_prev;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_ch_nxt   = CH_W'(ch_r);
          out_pos_nxt  = fin_r ? tgt_r : lerp_pos;
          out_done_nxt = done_r;
          out_last_nxt = !more_above;
          if (more_above) begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      start_time_r <= '0;
      dur_r        <= '0;
      done_r       <= 1'b1;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      start_time_r <= start_time_nxt;
      dur_r        <= dur_nxt;
      done_r       <= done_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    ch_r       <= ch_nxt;
    fin_r      <= fin_nxt;
    elapsed_r  <= elapsed_nxt;
    prod_r     <= prod_nxt;
    tgt_r      <= tgt_nxt;
    prev_r     <= prev_nxt;
    out_ch_r   <= out_ch_nxt;
    out_pos_r  <= out_pos_nxt;
    out_done_r <= out_done_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_pos_r, out_ch_r};
  assign out_tuser  = out_done_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // the divider only runs while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide step");

  // pose reads only for channels taking part in the tick
  a_mul_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> active_r[ch_r])
    else $error("pose read for an inactive channel");

  // a finished frame always reports done on its results
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && slot_free && fin_r) |=> (out_tvalid && out_tuser))
    else $error("finished frame result without done");

  // the divide step is only entered with the divider running
  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTART) |=> (state_r == S_DIV && div_stat.busy))
    else $error("divide step entered without the divider running");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for servo_frame_interpolator_unit: directed and random commands.
`timescale 1ns / 100ps

module testbench;
  import sfi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 120;
  localparam int ITEM_TARGET = 210;

  typedef struct packed {
    func_t              func;
    logic [3:0]         ch;
    logic signed [15:0] tgt;
    logic signed [15:0] strt;
    logic               act;
    logic [15:0]        dur;
    logic [31:0]        now;
  } servo_cmd_t;

  typedef struct packed {
    logic [3:0]  ch;
    logic [15:0] pos;
    logic        done;
    logic        last;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0]            in_tuser = FUNC_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // interpolator state mirror
  logic signed [15:0] pose_target [CHANNELS];
  logic signed [15:0] pose_start  [CHANNELS];
  logic [CHANNELS-1:0] active_chs;
  logic [31:0]         frame_t0;
  logic [15:0]         frame_len;
  logic                frame_done_q;

  drive_t pending_drives[$];
  drive_t got_drive;
  int     err_count = 0;
  int     sent_count = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  bit     tx_held = 1'b0;
  int     rx_mode = 0;
  int     rx_left = 0;

  servo_frame_interpolator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[servo_frame_interpolator_unit] ERROR");
      $finish;
    end
  end

  // receiver: randomly chosen stretches of full speed, light and heavy backpressure
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected result: channel %0d position %0d", out_tdata[3:0],
               $signed(out_tdata[19:4]));
        err_count++;
      end else begin
        got_drive = pending_drives.pop_front();
        if (out_tdata[3:0] !== got_drive.ch) begin
          $error("out_channel: expected %0d, got %0d", got_drive.ch, out_tdata[3:0]);
          err_count++;
        end
        if (out_tdata[19:4] !== got_drive.pos) begin
          $error("out_position: expected %0d, got %0d", $signed(got_drive.pos),
                 $signed(out_tdata[19:4]));
          err_count++;
        end
        if (out_tuser !== got_drive.done) begin
          $error("frame_done: expected %0d, got %0d", got_drive.done, out_tuser);
          err_count++;
        end
        if (out_tlast !== got_drive.last) begin
          $error("last: expected %0d, got %0d", got_drive.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  function automatic logic [15:0] lerp_q15(input int from_pos, input int to_pos,
                                           input int frac);
    int diff;
    int prod;
    int r;
    diff = to_pos / 2 - from_pos / 2;
    prod = diff * frac;
    r = from_pos + 2 * (prod >>> 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_command(input servo_cmd_t c);
    logic [31:0] elapsed;
    bit          finished;
    int          frac;
    int          n;
    drive_t      drives [CHANNELS];
    frac = 0;
    n = 0;
    case (c.func)
      FUNC_LOAD: begin
        if (c.ch < CHANNELS) begin
          pose_target[c.ch] = c.tgt;
          pose_start[c.ch] = c.strt;
          active_chs[c.ch] = c.act;
        end
      end
      FUNC_START: begin
        frame_t0 = c.now;
        frame_len = c.dur;
        frame_done_q = 1'b0;
      end
      FUNC_DISABLE: begin
        active_chs = '0;
        frame_done_q = 1'b1;
      end
      default: begin
        elapsed = c.now - frame_t0;
        finished = (elapsed >= {16'd0, frame_len});
        if (finished) frame_done_q = 1'b1;
        else frac = int'((64'd32767 * elapsed) / frame_len);
        for (int i = 0; i < CHANNELS; i++) begin
          if (active_chs[i]) begin
            drives[n].ch = i[3:0];
            drives[n].pos = finished ? pose_target[i] :
                            lerp_q15(int'(pose_start[i]), int'(pose_target[i]), frac);
            drives[n].done = frame_done_q;
            drives[n].last = 1'b0;
            n++;
          end
        end
        if (n > 0) drives[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_drives.push_back(drives[i]);
      end
    endcase
  endtask

  task automatic send_cmd(input servo_cmd_t c);
    if (burst_left == 0) begin
      // valid is already low here
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.func;
    in_tdata <= {3'b000, c.now, c.dur, c.act, c.strt, c.tgt, c.ch};
    do @(posedge clk); while (!in_tready);
    predict_command(c);
    sent_count++;
    burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      tx_held = 1'b0;
    end else begin
      tx_held = 1'b1;
    end
  endtask

  task automatic load(input logic [3:0] ch, input logic [15:0] tgt,
                      input logic [15:0] strt, input logic act);
    servo_cmd_t c;
    c = '0;
    c.func = FUNC_LOAD;
    c.ch = ch;
    c.tgt = tgt;
    c.strt = strt;
    c.act = act;
    send_cmd(c);
  endtask

  task automatic start_frame(input logic [31:0] now, input logic [15:0] dur);
    servo_cmd_t c;
    c = '0;
    c.func = FUNC_START;
    c.now = now;
    c.dur = dur;
    send_cmd(c);
  endtask

  task automatic tick(input logic [31:0] now);
    servo_cmd_t c;
    c = '0;
    c.func = FUNC_TICK;
    c.now = now;
    send_cmd(c);
  endtask

  task automatic deactivate_all();
    servo_cmd_t c;
    c = '0;
    c.func = FUNC_DISABLE;
    send_cmd(c);
  endtask

  // hold the sender until every expected transfer has come out
  task automatic wait_drained();
    if (tx_held) in_tvalid <= 1'b0;
    tx_held = 1'b0;
    burst_left = 0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 3) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_idle_after_reset();
    tick(32'd123);
  endtask

  task automatic test_pose_extremes();
    load(4'd0, 16'h7FFF, 16'h8000, 1'b1);
    load(4'd15, 16'h8000, 16'h7FFF, 1'b1);
    load(4'd7, 16'd1234, -16'sd1234, 1'b0);
    // start time near the top so elapsed wraps
    start_frame(32'hFFFF_FFF0, 16'hFFFF);
    tick(32'h0000_0010);
    tick(32'h0000_FFEE);
    tick(32'h0000_FFEF);
    // back inside the frame after it finished: done stays set
    tick(32'h0000_0000);
  endtask

  task automatic test_zero_duration();
    start_frame(32'd5, 16'd0);
    tick(32'd5);
    tick(32'd4);
  endtask

  task automatic test_load_mid_frame();
    start_frame(32'd1000, 16'd100);
    load(4'd3, 16'hFFFF, 16'd1, 1'b1);
    load(4'd5, -16'sd32767, 16'd3, 1'b1);
    tick(32'd1050);
  endtask

  task automatic test_deactivate();
    deactivate_all();
    tick(32'd2000);
    start_frame(32'd3000, 16'd10);
    tick(32'd3010);
    load(4'd9, 16'd100, -16'sd100, 1'b1);
    tick(32'd3005);
  endtask

  task automatic test_random_frames();
    servo_cmd_t  c;
    logic [31:0] t0;
    logic [31:0] el;
    logic [15:0] dur;
    int          kind;
    int          nt;
    while (sent_count < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: any command with arbitrary fields
        repeat ($urandom_range(1, 4)) begin
          c.func = func_t'($urandom_range(0, 3));
          c.ch = 4'($urandom);
          c.tgt = 16'($urandom);
          c.strt = 16'($urandom);
          c.act = 1'($urandom);
          c.dur = 16'($urandom);
          c.now = $urandom;
          send_cmd(c);
        end
      end else begin
        if (kind == 1) begin
          for (int i = 0; i < CHANNELS; i++) load(i[3:0], rand_pos(), rand_pos(), 1'b1);
        end else begin
          repeat ($urandom_range(0, 4))
            load(4'($urandom), rand_pos(), rand_pos(), $urandom_range(0, 3) != 0);
        end
        case ($urandom_range(0, 7))
          0:       dur = 16'd0;
          1:       dur = 16'hFFFF;
          2:       dur = 16'($urandom_range(1, 3));
          default: dur = 16'($urandom_range(4, 1500));
        endcase
        t0 = $urandom;
        start_frame(t0, dur);
        el = 0;
        nt = $urandom_range(1, 4);
        for (int k = 0; k < nt; k++) begin
          if ($urandom_range(0, 4) == 0)
            load(4'($urandom), rand_pos(), rand_pos(), $urandom_range(0, 3) != 0);
          el = el + $urandom_range(0, dur / 2 + 1);
          tick(t0 + el);
        end
        if ($urandom_range(0, 1) == 0) tick(t0 + dur + $urandom_range(0, 3));
        if ($urandom_range(0, 11) == 0) deactivate_all();
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
  endtask

  task automatic test_drain_and_resume();
    wait_drained();
    start_frame(32'd50000, 16'd40);
    tick(32'd50010);
    tick(32'd50039);
    tick(32'd50040);
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      pose_target[i] = '0;
      pose_start[i] = '0;
    end
    active_chs = '0;
    frame_t0 = '0;
    frame_len = '0;
    frame_done_q = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_after_reset();
    test_pose_extremes();
    test_zero_duration();
    test_load_mid_frame();
    test_deactivate();
    test_random_frames();
    test_drain_and_resume();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[servo_frame_interpolator_unit] OK");
    end else begin
      $display("[servo_frame_interpolator_unit] ERROR");
    end
    $finish;
  end

endmodule
